// ----- design/cmm_pkg.sv -----
// Shared constants for the complex 3x3 matrix multiplier
// Depends on nothing; used by the channel interfaces and the top level

package cmm_pkg;

  // default number format, signed Q8.24
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 24;

  // matrix geometry
  localparam int unsigned DIM      = 3;
  localparam int unsigned NUM_ELEM = DIM * DIM;

  // payload field widths
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned MODE_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // product modes
  localparam logic [MODE_W-1:0] MODE_A_B     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_A_BH    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AH_B    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

endpackage

// ----- design/cmm_if.sv -----
// Valid/ready channels of the complex 3x3 matrix multiplier
// Depends on cmm_pkg for field widths and default data width

interface cmm_req_if #(
  parameter int unsigned DATA_WIDTH = cmm_pkg::DATA_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic [cmm_pkg::KIND_W-1:0]       kind;
  logic [cmm_pkg::IDX_W-1:0]        element_index;
  logic signed [DATA_WIDTH-1:0]     real_part;
  logic signed [DATA_WIDTH-1:0]     imag_part;
  logic [cmm_pkg::MODE_W-1:0]       product_mode;

  modport source (
    output valid, kind, element_index, real_part, imag_part, product_mode,
    input  ready
  );
  modport sink (
    input  valid, kind, element_index, real_part, imag_part, product_mode,
    output ready
  );
endinterface

interface cmm_rsp_if #(
  parameter int unsigned DATA_WIDTH = cmm_pkg::DATA_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic [cmm_pkg::IDX_W-1:0]        result_index;
  logic signed [DATA_WIDTH-1:0]     result_real;
  logic signed [DATA_WIDTH-1:0]     result_imag;
  logic                             last;
  logic                             saturated;

  modport source (
    output valid, result_index, result_real, result_imag, last, saturated,
    input  ready
  );
  modport sink (
    input  valid, result_index, result_real, result_imag, last, saturated,
    output ready
  );
endinterface

// ----- design/complex_3x3_matrix_multiply.sv -----
// Complex 3x3 matrix multiplier, top level
// Depends on cmm_pkg and the cmm_req_if / cmm_rsp_if channel interfaces
//
// Usage:
//   req_i carries requests. A load request writes one complex element of A or
//   B at a row-major position; it is taken one per cycle while the block is
//   idle, and gives no response. A compute request picks A*B, A*B^H or A^H*B
//   and makes nine responses on rsp_o in row-major order, the ninth with last
//   set. Loads to a position above eight, kind three and mode three are
//   taken and dropped.
// Timing:
//   One shared signed multiplier does all twelve real products of an element,
//   one per cycle, behind an operand register and a product register; each
//   product is then accumulated, and once the pipeline drains the sum
//   saturates into the output register. req_i.ready stays low until the
//   ninth element sits in the output register.
// Stalls:
//   The response register holds while rsp_o.ready is low; the sequencer then
//   waits at the end of the next element.
// Reset:
//   rst_ni clears both matrices to zero, the sequencer and the output valid.

module complex_3x3_matrix_multiply #(
  parameter int unsigned DATA_WIDTH = cmm_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cmm_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cmm_req_if.sink            req_i,
  cmm_rsp_if.source          rsp_o
);

  localparam int unsigned PROD_W  = 2 * DATA_WIDTH;
  // six truncated products, each at most 2^(PROD_W-2-FRAC_BITS) in magnitude
  localparam int unsigned ACC_W   = PROD_W - FRAC_BITS + 3;
  localparam int unsigned ROW_W   = 2;
  localparam int unsigned STEP_W  = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(4 * cmm_pkg::DIM - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(cmm_pkg::DIM - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // row-major position major*3+minor without a multiplier
  function automatic logic [cmm_pkg::IDX_W-1:0] pos_of(
    input logic [ROW_W-1:0] major,
    input logic [ROW_W-1:0] minor
  );
    logic [cmm_pkg::IDX_W-1:0] m;
    m = cmm_pkg::IDX_W'(major);
    return (m << 1) + m + cmm_pkg::IDX_W'(minor);
  endfunction

  logic [1:0]                   state_q, state_d;
  logic [STEP_W-1:0]            step_q, step_d;
  logic [ROW_W-1:0]             row_q, row_d;
  logic [ROW_W-1:0]             col_q, col_d;
  logic [cmm_pkg::MODE_W-1:0]   mode_q;

  logic signed [DATA_WIDTH-1:0] a_re_q [cmm_pkg::NUM_ELEM];
  logic signed [DATA_WIDTH-1:0] a_im_q [cmm_pkg::NUM_ELEM];
  logic signed [DATA_WIDTH-1:0] b_re_q [cmm_pkg::NUM_ELEM];
  logic signed [DATA_WIDTH-1:0] b_im_q [cmm_pkg::NUM_ELEM];

  logic signed [DATA_WIDTH-1:0] op_x_q, op_y_q;
  logic                         p1_v_q, p1_neg_q, p1_im_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic                         p2_v_q, p2_neg_q, p2_im_q;
  logic signed [ACC_W-1:0]      acc_re_q, acc_im_q;

  logic                         out_v_q;
  logic [cmm_pkg::IDX_W-1:0]    out_idx_q;
  logic signed [DATA_WIDTH-1:0] out_re_q, out_im_q;
  logic                         out_last_q, out_sat_q;

  logic req_fire, start, issue, out_load, out_free;
  logic ca, cb;
  logic [1:0]                   term_sel;
  logic [ROW_W-1:0]             k_idx;
  logic [cmm_pkg::IDX_W-1:0]    ia, ib;
  logic signed [PROD_W-1:0]     prod_adj, prod_shr;
  logic signed [ACC_W-1:0]      term_val;
  logic                         clip_re, clip_im;
  logic signed [DATA_WIDTH-1:0] sat_re, sat_im;

  // request handshake
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign start       = req_fire && (req_i.kind == cmm_pkg::KIND_COMPUTE)
                       && (req_i.product_mode != cmm_pkg::MODE_INVALID);
  assign issue       = (state_q == ST_RUN);
  assign out_free    = !out_v_q || rsp_o.ready;
  assign out_load    = (state_q == ST_DRAIN) && !p1_v_q && !p2_v_q && out_free;

  // element stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cmm_pkg::NUM_ELEM; i++) begin
        a_re_q[i] <= '0;
        a_im_q[i] <= '0;
        b_re_q[i] <= '0;
        b_im_q[i] <= '0;
      end
    end else if (req_fire && (req_i.element_index < cmm_pkg::IDX_W'(cmm_pkg::NUM_ELEM))) begin
      if (req_i.kind == cmm_pkg::KIND_LOAD_A) begin
        a_re_q[req_i.element_index] <= req_i.real_part;
        a_im_q[req_i.element_index] <= req_i.imag_part;
      end else if (req_i.kind == cmm_pkg::KIND_LOAD_B) begin
        b_re_q[req_i.element_index] <= req_i.real_part;
        b_im_q[req_i.element_index] <= req_i.imag_part;
      end
    end
  end

  // operand addressing for the current step
  assign ca       = (mode_q == cmm_pkg::MODE_AH_B);
  assign cb       = (mode_q == cmm_pkg::MODE_A_BH);
  assign k_idx    = step_q[3:2];
  assign term_sel = step_q[1:0];

  always_comb begin
    unique case (mode_q)
      cmm_pkg::MODE_A_BH: begin
        ia = pos_of(row_q, k_idx);
        ib = pos_of(col_q, k_idx);
      end
      cmm_pkg::MODE_AH_B: begin
        ia = pos_of(k_idx, row_q);
        ib = pos_of(k_idx, col_q);
      end
      default: begin
        ia = pos_of(row_q, k_idx);
        ib = pos_of(k_idx, col_q);
      end
    endcase
  end

  // operand stage: ar*br, ai*bi to real; ar*bi, ai*br to imaginary
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      op_x_q   <= term_sel[0] ? a_im_q[ia] : a_re_q[ia];
      op_y_q   <= (term_sel[1] ^ term_sel[0]) ? b_im_q[ib] : b_re_q[ib];
      p1_im_q  <= term_sel[1];
      unique case (term_sel)
        2'd0:    p1_neg_q <= 1'b0;
        2'd1:    p1_neg_q <= (ca == cb);
        2'd2:    p1_neg_q <= cb;
        default: p1_neg_q <= ca;
      endcase
    end
  end

  // shared multiplier stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_v_q) begin
      prod_q   <= PROD_W'(op_x_q) * PROD_W'(op_y_q);
      p2_neg_q <= p1_neg_q;
      p2_im_q  <= p1_im_q;
    end
  end

  // sign, floor shift and accumulate
  always_comb begin
    prod_adj = p2_neg_q ? -prod_q : prod_q;
    prod_shr = prod_adj >>> FRAC_BITS;
    term_val = prod_shr[ACC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start || out_load) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (p2_v_q) begin
      if (p2_im_q) begin
        acc_im_q <= acc_im_q + term_val;
      end else begin
        acc_re_q <= acc_re_q + term_val;
      end
    end
  end

  // saturation to the data width
  always_comb begin
    clip_re = !((&acc_re_q[ACC_W-1:DATA_WIDTH-1]) || !(|acc_re_q[ACC_W-1:DATA_WIDTH-1]));
    clip_im = !((&acc_im_q[ACC_W-1:DATA_WIDTH-1]) || !(|acc_im_q[ACC_W-1:DATA_WIDTH-1]));
    if (!clip_re) begin
      sat_re = acc_re_q[DATA_WIDTH-1:0];
    end else if (acc_re_q[ACC_W-1]) begin
      sat_re = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      sat_re = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    if (!clip_im) begin
      sat_im = acc_im_q[DATA_WIDTH-1:0];
    end else if (acc_im_q[ACC_W-1]) begin
      sat_im = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      sat_im = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    row_d   = row_q;
    col_d   = col_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
          step_d  = '0;
          row_d   = '0;
          col_d   = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          step_d  = '0;
          state_d = ST_RUN;
          if (col_q == LAST_ROW) begin
            col_d = '0;
            row_d = row_q + ROW_W'(1);
            if (row_q == LAST_ROW) begin
              state_d = ST_IDLE;
            end
          end else begin
            col_d = col_q + ROW_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      mode_q  <= cmm_pkg::MODE_A_B;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (start) begin
        mode_q <= req_i.product_mode;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= pos_of(row_q, col_q);
      out_re_q   <= sat_re;
      out_im_q   <= sat_im;
      out_last_q <= (row_q == LAST_ROW) && (col_q == LAST_ROW);
      out_sat_q  <= clip_re || clip_im;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.result_index = out_idx_q;
  assign rsp_o.result_real  = out_re_q;
  assign rsp_o.result_imag  = out_im_q;
  assign rsp_o.last         = out_last_q;
  assign rsp_o.saturated    = out_sat_q;

`ifndef SYNTHESIS
  // no product in flight while the block takes requests
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_v_q || p2_v_q) |-> (state_q != ST_IDLE))
    else $error("multiplier pipeline busy while idle");

  // a product only follows an operand issue in the cycle before
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_v_q |-> $past(p1_v_q))
    else $error("product stage valid without operand stage");

  // the marked element is always the last position
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.last) |-> (rsp_o.result_index == pos_of(LAST_ROW, LAST_ROW)))
    else $error("last flag on wrong element");

  // a valid compute request closes the request channel
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !req_i.ready)
    else $error("request channel open after compute start");
`endif

endmodule
